/* rtl/core/lke_pkg.sv */
// ----------------------------------------------------------------------------
// lke_pkg
// Widths, kind codes and the quarter-wave table for the LED keyframe easing
// block.
// ----------------------------------------------------------------------------
package lke_pkg;

    localparam int COLOUR_BITS    = 16;
    localparam int PROG_FRAC_BITS = 16;
    localparam int COS_N          = 256;

    localparam int TIME_W     = 32;
    localparam int PROG_W     = PROG_FRAC_BITS + 1;
    localparam int IDX_W      = $clog2(COS_N + 1);
    localparam int MUL_A_W    = (COLOUR_BITS > PROG_W) ? COLOUR_BITS : PROG_W;
    localparam int MUL_W      = (MUL_A_W > IDX_W) ? MUL_A_W : IDX_W;
    localparam int ACC_W      = 2 * MUL_W + 1;
    localparam int DIV_CNT_W  = $clog2(PROG_FRAC_BITS);

    localparam logic [PROG_W-1:0]      PROG_ONE  = {1'b1, {PROG_FRAC_BITS{1'b0}}};
    localparam logic [COLOUR_BITS-1:0] MIN_LEVEL = COLOUR_BITS'(90);

    typedef enum logic [2:0] {
        KIND_OFF       = 3'd0,
        KIND_SOLID     = 3'd1,
        KIND_EASE_IN   = 3'd2,
        KIND_EASE_OUT  = 3'd3,
        KIND_PULSE_IN  = 3'd4,
        KIND_PULSE_OUT = 3'd5,
        KIND_LERP      = 3'd6,
        KIND_HOLD      = 3'd7
    } t_kind;

    typedef logic [PROG_W-1:0] t_omc_tab [0:COS_N];

    // 1 - cos(k*pi/(2N)) in Q1.F, from an eight-term series in Q2.30,
    // rounded to nearest. Evaluated at elaboration only.
    function automatic t_omc_tab build_omc();
        t_omc_tab    tab;
        logic [63:0] ang;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] cosq;
        logic [63:0] omc;
        logic [63:0] q30_one;
        logic [63:0] pi_q30;
        q30_one = 64'd1 << 30;
        pi_q30  = 64'd3373259426;
        for (int k = 0; k <= COS_N; k++) begin
            ang  = (64'(k) * pi_q30) / 64'(2 * COS_N);
            a2   = (ang * ang) >> 30;
            term = q30_one;
            pos  = q30_one;
            neg  = 64'd0;
            for (int n = 1; n <= 8; n++) begin
                term = ((term * a2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if ((n & 1) == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            cosq = (neg > pos) ? 64'd0 : pos - neg;
            if (cosq > q30_one) begin
                cosq = q30_one;
            end
            omc = q30_one - cosq;
            omc = (omc + (64'd1 << (29 - PROG_FRAC_BITS))) >> (30 - PROG_FRAC_BITS);
            if (omc > 64'(PROG_ONE)) begin
                omc = 64'(PROG_ONE);
            end
            tab[k] = omc[PROG_W-1:0];
        end
        return tab;
    endfunction

    localparam t_omc_tab OMC_TABLE = build_omc();

endpackage

/* rtl/core/led_keyframe_easing.sv */
// ----------------------------------------------------------------------------
// led_keyframe_easing
// RGBW keyframe easing: per tick word, progress through the keyframe is
// shaped by the keyframe kind and applied to four held channel duties.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tuser kind,starting; tdata times, colours
//  m_*       out  m_tvalid/m_tready    tuser updated; tdata red..white
//
// Off, solid and hold words skip the progress divider and the multiplier. Ease
// and pulse words pass through the one-bit-per-cycle progress divider and the
// single shared multiplier, which lerp words use twice per channel. A zero
// duration or an elapsed time at or past the duration skips the divider's
// bit steps. s_tready is high only between words; a result waiting on m_tready
// does not block the next word, but holds its output step.
// Reset (synchronous, active low) clears the held duties to zero.
// ----------------------------------------------------------------------------
module led_keyframe_easing (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] elapsed, [63:32] duration, [79:64] from_red,
    // [95:80] from_green, [111:96] from_blue, [127:112] from_white,
    // [143:128] to_red, [159:144] to_green, [175:160] to_blue, [191:176] to_white
    input  logic [191:0] s_tdata,
    // [2:0] kind, [3] starting
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] red, [31:16] green, [47:32] blue, [63:48] white
    output logic [63:0]  m_tdata,
    // [0] updated
    output logic [0:0]   m_tuser
);
    import lke_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIMPLE,
        S_DIV,
        S_PREP,
        S_FAC,
        S_MUL,
        S_ACC,
        S_WR,
        S_OUT
    } t_state;

    t_state                 r_state;
    t_kind                  r_kind;
    logic                   r_start;
    logic [COLOUR_BITS-1:0] r_from [4];
    logic [COLOUR_BITS-1:0] r_to   [4];
    logic [COLOUR_BITS-1:0] r_held [4];
    logic [PROG_W-1:0]      r_p;
    logic [PROG_W-1:0]      r_q;
    logic [PROG_W-1:0]      r_fac;
    logic [ACC_W-1:0]       r_acc;
    logic [1:0]             r_ch;
    logic                   r_upd;
    logic                   r_m_valid;
    logic [63:0]            r_m_data;
    logic                   r_m_user;

    logic                   s_accept;
    t_kind                  in_kind;
    logic                   in_simple;
    logic                   div_start;
    logic                   div_done;
    logic [PROG_W-1:0]      div_quot;
    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic [2*MUL_W-1:0]     mul_prod;
    logic [COLOUR_BITS-1:0] ch_raw;
    logic [COLOUR_BITS-1:0] ch_val;
    logic [IDX_W-1:0]       tab_idx;

    assign s_tready  = (r_state == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_kind   = t_kind'(s_tuser[2:0]);
    assign in_simple = (in_kind inside {KIND_OFF, KIND_SOLID, KIND_HOLD});
    assign div_start = s_accept && !in_simple;

    lke_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_elapsed  (s_tdata[31:0]),
        .i_duration (s_tdata[63:32]),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_PREP: begin
                mul_a = MUL_W'(r_q);
                mul_b = (r_kind == KIND_PULSE_OUT) ? MUL_W'(COS_N) : MUL_W'(r_q);
            end
            S_MUL: begin
                mul_a = MUL_W'(r_from[r_ch]);
                mul_b = MUL_W'(r_fac);
            end
            S_ACC: begin
                mul_a = MUL_W'(r_to[r_ch]);
                mul_b = MUL_W'(r_p);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;
    assign tab_idx  = r_acc[PROG_FRAC_BITS +: IDX_W];

    // A shaped channel never exceeds its input colour, so the low bits above
    // the fraction hold the whole result.
    assign ch_raw = r_acc[PROG_FRAC_BITS +: COLOUR_BITS];
    always_comb begin
        if (r_kind == KIND_LERP) begin
            ch_val = ch_raw;
        end else begin
            ch_val = (ch_raw < MIN_LEVEL) ? MIN_LEVEL : ch_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_ch      <= '0;
            for (int i = 0; i < 4; i++) begin
                r_held[i] <= '0;
            end
        end else begin
            if (r_m_valid && m_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_kind  <= in_kind;
                        r_start <= s_tuser[3];
                        for (int i = 0; i < 4; i++) begin
                            r_from[i] <= s_tdata[64 + 16*i +: COLOUR_BITS];
                            r_to[i]   <= s_tdata[128 + 16*i +: COLOUR_BITS];
                        end
                        r_state <= in_simple ? S_SIMPLE : S_DIV;
                    end
                end
                S_SIMPLE: begin
                    r_upd <= r_start && (r_kind != KIND_HOLD);
                    if (r_start && (r_kind != KIND_HOLD)) begin
                        for (int i = 0; i < 4; i++) begin
                            r_held[i] <= (r_kind == KIND_OFF) ? '0 : r_from[i];
                        end
                    end
                    r_state <= S_OUT;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_p  <= div_quot;
                        r_q  <= (r_kind inside {KIND_EASE_OUT, KIND_PULSE_OUT}) ?
                                PROG_ONE - div_quot : div_quot;
                        r_ch <= '0;
                        if (r_kind == KIND_LERP) begin
                            r_fac   <= PROG_ONE - div_quot;
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_acc   <= ACC_W'(mul_prod);
                    r_state <= S_FAC;
                end
                S_FAC: begin
                    // Index stays within the table since q never exceeds one.
                    if (r_kind == KIND_PULSE_OUT) begin
                        r_fac <= OMC_TABLE[tab_idx];
                    end else begin
                        r_fac <= r_acc[PROG_FRAC_BITS +: PROG_W];
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc   <= ACC_W'(mul_prod);
                    r_state <= (r_kind == KIND_LERP) ? S_ACC : S_WR;
                end
                S_ACC: begin
                    r_acc   <= r_acc + ACC_W'(mul_prod);
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_held[r_ch] <= ch_val;
                    r_upd        <= 1'b1;
                    r_ch         <= r_ch + 1'b1;
                    r_state      <= (r_ch == 2'd3) ? S_OUT : S_MUL;
                end
                S_OUT: begin
                    if (!r_m_valid || m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {16'(r_held[3]), 16'(r_held[2]),
                                      16'(r_held[1]), 16'(r_held[0])};
                        r_m_user  <= r_upd;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = r_m_valid;
    assign m_tdata    = r_m_data;
    assign m_tuser[0] = r_m_user;

endmodule

/* rtl/core/lke_div.sv */
// ----------------------------------------------------------------------------
// lke_div
// Progress divider: elapsed * 2^F / duration, one quotient bit per cycle,
// with elapsed clamped to duration and a zero duration giving one.
// ----------------------------------------------------------------------------
module lke_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lke_pkg::TIME_W-1:0]   i_elapsed,
    input  logic [lke_pkg::TIME_W-1:0]   i_duration,
    output logic                         o_done,
    output logic [lke_pkg::PROG_W-1:0]   o_quot
);
    import lke_pkg::*;

    logic [TIME_W-1:0]    r_rem;
    logic [TIME_W-1:0]    r_div;
    logic [PROG_W-1:0]    r_quot;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [TIME_W:0] rem2;
    logic [TIME_W:0] diff;
    logic            ge;

    // The remainder always stays below the divisor, so the shifted value
    // fits one extra bit.
    assign rem2 = {r_rem, 1'b0};
    assign diff = rem2 - {1'b0, r_div};
    assign ge   = (rem2 >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_div <= i_duration;
                r_rem <= i_elapsed;
                if ((i_duration == '0) || (i_elapsed >= i_duration)) begin
                    r_quot <= PROG_ONE;
                    r_done <= 1'b1;
                end else begin
                    r_quot <= '0;
                    r_cnt  <= DIV_CNT_W'(PROG_FRAC_BITS - 1);
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                end
            end else if (r_busy) begin
                r_rem  <= ge ? diff[TIME_W-1:0] : rem2[TIME_W-1:0];
                r_quot <= {r_quot[PROG_W-2:0], ge};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == '0);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* rtl/core/lke_check.sv */
// ----------------------------------------------------------------------------
// lke_check
// Port-level checks for the LED keyframe easing block, bound to the top level.
// ----------------------------------------------------------------------------
module lke_check (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic [0:0]   m_tuser
);
    logic [63:0] r_last_data;
    logic        s_accept;

    assign s_accept = s_tvalid && s_tready;

    // Last delivered duties; before any delivery the held duties are zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_data <= '0;
        end else if (m_tvalid && m_tready) begin
            r_last_data <= m_tdata;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !s_tready)
        else $error("input ready right after a word was taken");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after a word was taken");

    a_unchanged_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == r_last_data)
        else $error("duties changed on a word that reports no update");

endmodule

bind led_keyframe_easing lke_check u_lke_check (.*);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for led_keyframe_easing. A short table of directed tick
// words covers reset, every kind, zero and clamped durations and the floor
// level. Random keyframe sequences follow, and every result word is checked
// against a predictor of the held RGBW duties.
// ----------------------------------------------------------------------------
module testbench;

    import lke_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_WORDS   = 900;
    localparam logic [63:0] FLOOR_LEVEL    = 64'd90;
    localparam logic [63:0] UNIT           = 64'd1 << PROG_FRAC_BITS;

    typedef struct packed {
        logic [63:0] duty;
        logic        upd;
    } t_duty_word;

    typedef struct {
        t_kind       kind;
        bit          starting;
        logic [31:0] elapsed;
        logic [31:0] duration;
        logic [63:0] from_c;
        logic [63:0] to_c;
        bit          typed;
        logic [63:0] duty;
        bit          upd;
    } t_tick_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // [31:0] elapsed, [63:32] duration, [127:64] from colour, [191:128] to colour
    logic [191:0] s_tdata = '0;
    // [2:0] kind, [3] starting
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [15:0] red, [31:16] green, [47:32] blue, [63:48] white
    logic [63:0]  m_tdata;
    // [0] updated
    logic [0:0]   m_tuser;

    logic [63:0]  omc_wave [0:COS_N];
    logic [15:0]  held_duty [4];
    t_duty_word   pending_duty [$];
    t_tick_row    tick_rows [$];
    int           errors = 0;
    int           words_sent = 0;
    int           words_checked = 0;
    int           kind_seen [8];
    bit           quiet_tx = 1'b0;
    bit           quiet_rx = 1'b0;
    string        ch_name [4] = '{"red", "green", "blue", "white"};

    led_keyframe_easing dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One minus cosine over a quarter wave, from an eight-term series in Q2.30,
    // rounded into the progress fraction.
    function automatic void fill_omc_wave();
        logic [63:0] ang;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] cosq;
        logic [63:0] omc;
        logic [63:0] q30;
        q30 = 64'd1 << 30;
        for (int k = 0; k <= COS_N; k++) begin
            ang  = (64'(k) * 64'd3373259426) / 64'(2 * COS_N);
            a2   = (ang * ang) >> 30;
            term = q30;
            pos  = q30;
            neg  = 64'd0;
            for (int n = 1; n <= 8; n++) begin
                term = ((term * a2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) begin
                    neg += term;
                end else begin
                    pos += term;
                end
            end
            cosq = (neg > pos) ? 64'd0 : pos - neg;
            if (cosq > q30) begin
                cosq = q30;
            end
            omc = ((q30 - cosq) + (64'd1 << (29 - PROG_FRAC_BITS))) >> (30 - PROG_FRAC_BITS);
            omc_wave[k] = (omc > UNIT) ? UNIT : omc;
        end
    endfunction

    function automatic logic [15:0] at_floor(input logic [63:0] v);
        at_floor = (v < FLOOR_LEVEL) ? FLOOR_LEVEL[15:0] : v[15:0];
    endfunction

    // Advances the held duties by one tick word and returns what the block shows.
    function automatic t_duty_word predict_tick(input t_tick_row r);
        t_duty_word  res;
        logic [63:0] prog;
        logic [63:0] shaped;
        logic [63:0] sq;
        logic [63:0] idx;
        logic [63:0] fc;
        logic [63:0] tc;
        if (r.duration == 32'd0) begin
            prog = UNIT;
        end else begin
            prog = (64'((r.elapsed > r.duration) ? r.duration : r.elapsed) << PROG_FRAC_BITS)
                   / 64'(r.duration);
        end
        shaped = (r.kind == KIND_EASE_OUT || r.kind == KIND_PULSE_OUT) ? UNIT - prog : prog;
        sq  = (shaped * shaped) >> PROG_FRAC_BITS;
        idx = (shaped * 64'(COS_N)) >> PROG_FRAC_BITS;
        if (idx > 64'(COS_N)) begin
            idx = 64'(COS_N);
        end
        res.upd = 1'b0;
        for (int ch = 0; ch < 4; ch++) begin
            fc = 64'(r.from_c[16*ch +: 16]);
            tc = 64'(r.to_c[16*ch +: 16]);
            case (r.kind)
                KIND_OFF, KIND_SOLID: begin
                    if (r.starting) begin
                        held_duty[ch] = (r.kind == KIND_OFF) ? 16'd0 : fc[15:0];
                        res.upd = 1'b1;
                    end
                end
                KIND_EASE_IN, KIND_EASE_OUT, KIND_PULSE_IN: begin
                    held_duty[ch] = at_floor((fc * sq) >> PROG_FRAC_BITS);
                    res.upd = 1'b1;
                end
                KIND_PULSE_OUT: begin
                    held_duty[ch] = at_floor((fc * omc_wave[idx]) >> PROG_FRAC_BITS);
                    res.upd = 1'b1;
                end
                KIND_LERP: begin
                    held_duty[ch] = 16'((fc * (UNIT - prog) + tc * prog) >> PROG_FRAC_BITS);
                    res.upd = 1'b1;
                end
                default: begin
                end
            endcase
        end
        res.duty = {held_duty[3], held_duty[2], held_duty[1], held_duty[0]};
        return res;
    endfunction

    function automatic void add_row(input t_kind kind, input bit starting,
                                    input logic [31:0] elapsed, input logic [31:0] duration,
                                    input logic [63:0] from_c, input logic [63:0] to_c,
                                    input bit typed, input logic [63:0] duty, input bit upd);
        t_tick_row r;
        r = '{kind, starting, elapsed, duration, from_c, to_c, typed, duty, upd};
        tick_rows.push_back(r);
    endfunction

    function automatic int draw_wait(input bit quiet);
        draw_wait = quiet ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [15:0] rand_level();
        case ($urandom_range(0, 5))
            0:       rand_level = 16'h0000;
            1:       rand_level = 16'hFFFF;
            2:       rand_level = 16'($urandom_range(0, 200));
            default: rand_level = 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_colour();
        rand_colour = {rand_level(), rand_level(), rand_level(), rand_level()};
    endfunction

    function automatic logic [31:0] rand_duration();
        case ($urandom_range(0, 9))
            0:       rand_duration = 32'd0;
            1:       rand_duration = 32'($urandom);
            2, 3, 4: rand_duration = 32'($urandom_range(1, 20));
            default: rand_duration = 32'($urandom_range(1, 5000));
        endcase
    endfunction

    // Sends one tick word and records what it should produce once accepted.
    task automatic send_word(input t_tick_row r);
        t_duty_word pred;
        int         gap;
        if ($urandom_range(0, 39) == 0) begin
            quiet_tx = !quiet_tx;
        end
        gap = draw_wait(quiet_tx);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {r.starting, r.kind};
        s_tdata  <= {r.to_c, r.from_c, r.duration, r.elapsed};
        do @(posedge i_clk); while (!s_tready);
        pred = predict_tick(r);
        if (r.typed) begin
            pred.duty = r.duty;
            pred.upd  = r.upd;
        end
        pending_duty.push_back(pred);
        words_sent++;
        kind_seen[r.kind]++;
        @(negedge i_clk);
    endtask

    // Result side: random stalls on m_tready, each word checked as it is taken.
    initial begin : result_side
        t_duty_word want;
        int         stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 39) == 0) begin
                quiet_rx = !quiet_rx;
            end
            stall = draw_wait(quiet_rx);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            words_checked++;
            if (pending_duty.size() == 0) begin
                $display("%0t: result word with nothing expected, got %h / %b",
                         $time, m_tdata, m_tuser[0]);
                errors++;
            end else begin
                want = pending_duty.pop_front();
                for (int ch = 0; ch < 4; ch++) begin
                    if (m_tdata[16*ch +: 16] !== want.duty[16*ch +: 16]) begin
                        $display("%0t: %s expected %h, got %h", $time, ch_name[ch],
                                 want.duty[16*ch +: 16], m_tdata[16*ch +: 16]);
                        errors++;
                    end
                end
                if (m_tuser[0] !== want.upd) begin
                    $display("%0t: updated expected %b, got %b", $time, want.upd, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[led_keyframe_easing] ERROR");
        $finish;
    end

    initial begin : stimulus
        t_tick_row   r;
        int          random_sent;
        int          ticks;
        logic [31:0] step;
        for (int k = 0; k < 8; k++) begin
            kind_seen[k] = 0;
        end
        for (int ch = 0; ch < 4; ch++) begin
            held_duty[ch] = 16'd0;
        end
        fill_omc_wave();

        // Directed table: expected duties typed in only where they are evident.
        add_row(KIND_HOLD, 0, 50, 100, 64'h1234_5678_9ABC_DEF0, 64'h0, 1, 64'h0, 0);
        add_row(KIND_OFF, 0, 0, 100, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1, 64'h0, 0);
        add_row(KIND_OFF, 1, 0, 100, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1, 64'h0, 1);
        add_row(KIND_SOLID, 1, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1,
                64'hFFFF_FFFF_FFFF_FFFF, 1);
        add_row(KIND_SOLID, 0, 0, 0, 64'h1234_5678_9ABC_DEF0, 64'h0, 1,
                64'hFFFF_FFFF_FFFF_FFFF, 0);
        add_row(KIND_HOLD, 1, 7, 9, 64'h0, 64'h0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        add_row(KIND_SOLID, 1, 3, 3, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1,
                64'hFFFF_FFFF_FFFF_FFFF, 1);
        add_row(KIND_EASE_IN, 0, 0, 0, 64'hFFFF_8000_0100_005A, 64'h0, 1,
                64'hFFFF_8000_0100_005A, 1);
        add_row(KIND_EASE_OUT, 1, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1,
                64'h005A_005A_005A_005A, 1);
        add_row(KIND_PULSE_IN, 0, 9, 0, 64'h0, 64'h0, 1, 64'h005A_005A_005A_005A, 1);
        add_row(KIND_PULSE_OUT, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1,
                64'h005A_005A_005A_005A, 1);
        add_row(KIND_LERP, 0, 0, 0, 64'h0, 64'hFFFF_AAAA_5555_0001, 1,
                64'hFFFF_AAAA_5555_0001, 1);
        add_row(KIND_LERP, 0, 0, 32'hFFFF_FFFF, 64'h0001_5555_AAAA_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0001_5555_AAAA_FFFF, 1);
        add_row(KIND_LERP, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0,
                64'h8001_4002_2004_1008, 1, 64'h8001_4002_2004_1008, 1);
        // Elapsed beyond duration clamps to full progress.
        add_row(KIND_EASE_IN, 0, 32'hFFFF_FFFF, 5, 64'hFFFF_1234_00FF_5A5A, 64'h0, 1,
                64'hFFFF_1234_00FF_5A5A, 1);
        add_row(KIND_PULSE_OUT, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                64'h0, 1, 64'h005A_005A_005A_005A, 1);
        add_row(KIND_EASE_IN, 0, 1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1,
                64'h005A_005A_005A_005A, 1);
        add_row(KIND_PULSE_OUT, 0, 0, 1000, 64'hFFFF_C000_0800_0040, 64'h0, 0, 64'h0, 0);
        add_row(KIND_EASE_OUT, 0, 1, 3, 64'hFFFF_7FFF_0200_0050, 64'h0, 0, 64'h0, 0);
        add_row(KIND_PULSE_IN, 0, 2, 3, 64'hFFFF_1000_0300_00A0, 64'h0, 0, 64'h0, 0);
        add_row(KIND_PULSE_OUT, 0, 5, 11, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 0, 64'h0, 0);
        add_row(KIND_LERP, 0, 3, 7, 64'hFFFF_0000_1234_8000, 64'h0000_FFFF_4321_7FFF,
                0, 64'h0, 0);
        add_row(KIND_OFF, 0, 4, 7, 64'h0, 64'h0, 0, 64'h0, 0);
        add_row(KIND_SOLID, 1, 0, 1, 64'h5555_AAAA_5555_AAAA, 64'h0, 0, 64'h0, 0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (tick_rows[i]) begin
            send_word(tick_rows[i]);
        end

        // Random part: mostly keyframes played as a run of ticks, some noise.
        random_sent = 0;
        while (random_sent < RANDOM_WORDS) begin
            r.typed = 1'b0;
            r.duty  = 64'h0;
            r.upd   = 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                r.kind     = t_kind'(3'($urandom_range(0, 7)));
                r.starting = 1'($urandom);
                r.elapsed  = 32'($urandom);
                r.duration = ($urandom_range(0, 1) == 0) ? 32'($urandom) : rand_duration();
                r.from_c   = {32'($urandom), 32'($urandom)};
                r.to_c     = {32'($urandom), 32'($urandom)};
                send_word(r);
                random_sent++;
            end else begin
                r.kind     = t_kind'(3'($urandom_range(0, 7)));
                r.duration = rand_duration();
                r.from_c   = rand_colour();
                r.to_c     = rand_colour();
                r.elapsed  = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 50)) : 32'd0;
                // A keyframe that is entered without its starting flag now and then.
                r.starting = ($urandom_range(0, 9) != 0);
                ticks      = $urandom_range(1, 10);
                step       = (r.duration > 32'd8) ? r.duration / 32'd6 : 32'd1;
                for (int t = 0; t < ticks; t++) begin
                    send_word(r);
                    random_sent++;
                    r.starting = 1'b0;
                    r.elapsed  = r.elapsed + 32'($urandom_range(0, 32'(step)));
                end
            end
        end
        s_tvalid <= 1'b0;

        while (pending_duty.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        $display("Sent %0d tick words (off %0d, solid %0d, ease in %0d, ease out %0d,",
                 words_sent, kind_seen[KIND_OFF], kind_seen[KIND_SOLID],
                 kind_seen[KIND_EASE_IN], kind_seen[KIND_EASE_OUT]);
        $display("pulse in %0d, pulse out %0d, lerp %0d, hold %0d); checked %0d results.",
                 kind_seen[KIND_PULSE_IN], kind_seen[KIND_PULSE_OUT],
                 kind_seen[KIND_LERP], kind_seen[KIND_HOLD], words_checked);
        if (errors == 0) begin
            $display("[led_keyframe_easing] OK");
        end else begin
            $display("[led_keyframe_easing] ERROR");
        end
        $finish;
    end

endmodule
